// ===== rtl/core/sorted_set_merge_engine_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_set_merge_engine_defines.svh
// Assertion macros shared by the merge engine RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_MERGE_ENGINE_DEFINES_SVH
`define SORTED_SET_MERGE_ENGINE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SSM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("merge engine check failed");

// antecedent implies consequent in the next cycle
`define SSM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("merge engine check failed");

`endif

// ===== rtl/core/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Types, codes and helpers of the sorted set merge engine.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int SET_DEPTH = 32;
  localparam int KEY_W     = 32;
  localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // input operation codes
  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  // set operation codes
  localparam logic [1:0] SET_OR    = 2'd0;
  localparam logic [1:0] SET_INTER = 2'd1;
  localparam logic [1:0] SET_DIFF  = 2'd2;
  localparam logic [1:0] SET_XOR   = 2'd3;

  // configuration register indexes
  localparam logic CFG_SET_OP = 1'b0;
  localparam logic CFG_SIGNED = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic        has_key;
    logic        last;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic disorder;
  } load_chk_t;

  // a below b; signed mode flips the sign bits
  function automatic logic key_less(key_t a, key_t b, logic sgn);
    key_t ax;
    key_t bx;
    ax = a;
    bx = b;
    ax[KEY_W-1] = a[KEY_W-1] ^ sgn;
    bx[KEY_W-1] = b[KEY_W-1] ^ sgn;
    return ax < bx;
  endfunction

endpackage

// ===== rtl/core/sorted_set_merge_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_set_merge_engine
// Loads two ascending key sets and merges them as a set operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a beat is taken when start is high and busy is low. Operation
//   0/1 appends in_item.key to the left/right store in that cycle (busy
//   stays low, no result). Operation 2 runs the merge; code 3 is ignored.
//   Loads that overflow or break strict ascending order are dropped and
//   raise status bits, reported on every result beat of the next run.
//   Config: cfg_we writes cfg_wdata to register cfg_idx (0 set operation,
//   1 signed compare); the user must write it only while idle (unchecked).
//   Output: one result beat per out_valid pulse, ascending keys, last on
//   the final beat; an empty result is a single beat with has_key 0.
//   The receiver cannot stall; beats are simply presented for one cycle.
// Timing:
//   A run walks in steps, at most left_count+right_count of them; each
//   walk step is one registered memory read (S_WAIT) followed by the
//   compare/advance state (S_STEP). busy drops on the cycle the last
//   beat is shown; both stores and the error flags clear at that point.
// Reset: synchronous, clears counts, flags, config and control; the key
//   memories are not cleared, and words beyond the counts are never used.
// ----------------------------------------------------------------------------
`include "sorted_set_merge_engine_defines.svh"

module sorted_set_merge_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ssm_pkg::in_item_t in_item,
  output logic              out_valid,
  output ssm_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [1:0]        cfg_wdata
);
  import ssm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_STEP,
    S_FLUSH
  } state_t;

  state_t    state_r;
  logic      busy_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic [1:0] set_op_r;
  logic       sgn_r;
  logic [1:0] err_r;

  cnt_t lcnt_r, rcnt_r;
  key_t llast_r, rlast_r;
  cnt_t li_r, rj_r;

  // key stores, registered read port
  key_t left_mem  [SET_DEPTH];
  key_t right_mem [SET_DEPTH];
  key_t lq_r, rq_r;

  // one-deep hold so the final beat can carry last
  key_t pend_r;
  logic pend_v_r;

  // load path
  logic      start_acc;
  logic      is_left, is_right;
  cnt_t      sel_cnt;
  key_t      sel_last;
  load_chk_t chk;
  logic      wr_left, wr_right;

  assign start_acc = start && !busy_r;
  assign is_left   = (in_item.operation == OP_LOAD_LEFT);
  assign is_right  = (in_item.operation == OP_LOAD_RIGHT);
  assign sel_cnt   = is_right ? rcnt_r : lcnt_r;
  assign sel_last  = is_right ? rlast_r : llast_r;

  ssm_load_chk u_load_chk (
    .cnt      (sel_cnt),
    .last_key (sel_last),
    .key      (in_item.key),
    .sgn      (sgn_r),
    .chk      (chk)
  );

  assign wr_left  = start_acc && is_left  && !chk.full && !chk.disorder;
  assign wr_right = start_acc && is_right && !chk.full && !chk.disorder;

  // walk step
  logic keep_l, keep_r, keep_b;
  logic lv, rv, lt, eq;
  logic take_l, take_r, take_b;
  logic emit, walk_done;
  key_t emit_key;

  assign keep_l = (set_op_r == SET_OR) || (set_op_r == SET_DIFF) || (set_op_r == SET_XOR);
  assign keep_r = (set_op_r == SET_OR) || (set_op_r == SET_XOR);
  assign keep_b = (set_op_r == SET_OR) || (set_op_r == SET_INTER);

  assign lv = (li_r < lcnt_r);
  assign rv = (rj_r < rcnt_r);
  assign lt = key_less(lq_r, rq_r, sgn_r);
  assign eq = (lq_r == rq_r);

  // a lone tail behaves as the smaller side
  assign take_l    = lv && (!rv || lt);
  assign take_r    = rv && (!lv || (!lt && !eq));
  assign take_b    = lv && rv && eq;
  assign walk_done = !lv && !rv;
  assign emit      = (take_l && keep_l) || (take_r && keep_r) || (take_b && keep_b);
  assign emit_key  = take_r ? rq_r : lq_r;

  // memories: writes only while idle; the read port is registered and always enabled
  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[lcnt_r[ADDR_W-1:0]] <= in_item.key;
    end
    if (wr_right) begin
      right_mem[rcnt_r[ADDR_W-1:0]] <= in_item.key;
    end
    lq_r <= left_mem[li_r[ADDR_W-1:0]];
    rq_r <= right_mem[rj_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      set_op_r    <= SET_OR;
      sgn_r       <= 1'b0;
      err_r       <= '0;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      li_r        <= '0;
      rj_r        <= '0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SET_OP: set_op_r <= cfg_wdata;
          CFG_SIGNED: sgn_r    <= cfg_wdata[0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (start_acc) begin
            unique case (in_item.operation)
              OP_LOAD_LEFT, OP_LOAD_RIGHT: begin
                if (chk.full) begin
                  err_r[0] <= 1'b1;
                end else if (chk.disorder) begin
                  err_r[1] <= 1'b1;
                end else if (is_left) begin
                  lcnt_r  <= lcnt_r + 1'b1;
                  llast_r <= in_item.key;
                end else begin
                  rcnt_r  <= rcnt_r + 1'b1;
                  rlast_r <= in_item.key;
                end
              end
              OP_RUN: begin
                li_r     <= '0;
                rj_r     <= '0;
                pend_v_r <= 1'b0;
                busy_r   <= 1'b1;
                state_r  <= S_WAIT;
              end
              default: ;
            endcase
          end
        end

        // the registered read of li_r/rj_r is taken here; S_STEP uses its data
        S_WAIT: begin
          state_r <= S_STEP;
        end

        S_STEP: begin
          if (walk_done) begin
            state_r <= S_FLUSH;
          end else begin
            if (emit) begin
              if (pend_v_r) begin
                out_valid_r         <= 1'b1;
                out_item_r.out_key  <= pend_r;
                out_item_r.has_key  <= 1'b1;
                out_item_r.last     <= 1'b0;
                out_item_r.status   <= err_r;
              end
              pend_r   <= emit_key;
              pend_v_r <= 1'b1;
            end
            if (take_l || take_b) begin
              li_r <= li_r + 1'b1;
            end
            if (take_r || take_b) begin
              rj_r <= rj_r + 1'b1;
            end
            state_r <= S_WAIT;
          end
        end

        // final beat: held key, or the empty marker
        S_FLUSH: begin
          out_valid_r        <= 1'b1;
          out_item_r.out_key <= pend_v_r ? pend_r : '0;
          out_item_r.has_key <= pend_v_r;
          out_item_r.last    <= 1'b1;
          out_item_r.status  <= err_r;
          lcnt_r             <= '0;
          rcnt_r             <= '0;
          err_r              <= '0;
          pend_v_r           <= 1'b0;
          busy_r             <= 1'b0;
          state_r            <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a run always ends on its last beat: busy is already low when it is shown
  `SSM_ASSERT_NOW(a_last_ends_run, out_valid && out_item.last, !busy)
  // the empty marker is only ever the final beat
  `SSM_ASSERT_NOW(a_empty_is_last, out_valid && !out_item.has_key, out_item.last)
  // fill counts stay within the store depth
  `SSM_ASSERT_NOW(a_cnt_bound, 1'b1, (lcnt_r <= CNT_W'(SET_DEPTH)) && (rcnt_r <= CNT_W'(SET_DEPTH)))
  // an accepted run raises busy
  `SSM_ASSERT_NEXT(a_run_busy, start && !busy && (in_item.operation == OP_RUN), busy)

endmodule

// ===== rtl/core/ssm_load_chk.sv =====
// ----------------------------------------------------------------------------
// ssm_load_chk
// Checks one load beat against the fill count and last key of its store.
// ----------------------------------------------------------------------------
module ssm_load_chk (
  input  ssm_pkg::cnt_t      cnt,
  input  ssm_pkg::key_t      last_key,
  input  ssm_pkg::key_t      key,
  input  logic               sgn,
  output ssm_pkg::load_chk_t chk
);
  import ssm_pkg::*;

  logic full;

  assign full         = (cnt >= CNT_W'(SET_DEPTH));
  // overflow wins over order
  assign chk.full     = full;
  assign chk.disorder = !full && (cnt != '0) && !key_less(last_key, key, sgn);

endmodule

// ===== test/sorted_set_merge_engine_tb.sv =====
// ----------------------------------------------------------------------------
// testbench
// Sorted set merge engine: directed set-operation and error cases, then
// random load/run sequences over changing idle patterns and register
// settings. Every result beat is scored against a behavioral merge.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  // operation code the block must ignore
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // store sides and status flag bits
  localparam int LEFT_SIDE     = 0;
  localparam int RIGHT_SIDE    = 1;
  localparam int FLAG_OVERFLOW = 0;
  localparam int FLAG_DISORDER = 1;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 6;
  // spare cycles after draining, so loads have settled before a register write
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BEATS  = 280;

  // --------------------------------------------------------------------------
  // Behavioral merge: mirrors both key stores, the flags and the registers,
  // and queues the result beats each accepted run must produce.
  // --------------------------------------------------------------------------
  class merge_checker;
    key_t       key_store[2][SET_DEPTH];
    int         fill[2];
    logic [1:0] load_flags;
    logic [1:0] set_op;
    logic       signed_keys;
    out_item_t  merged_beats[$];
    int         mismatches;

    function new();
      fill[LEFT_SIDE]  = 0;
      fill[RIGHT_SIDE] = 0;
      load_flags  = '0;
      set_op      = SET_OR;
      signed_keys = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_register(logic idx, logic [1:0] value);
      if (idx == CFG_SET_OP) set_op = value;
      else signed_keys = value[0];
    endfunction

    // strict order under the current compare mode
    function bit key_below(key_t a, key_t b);
      key_t flip;
      flip = '0;
      flip[KEY_W-1] = signed_keys;
      return (a ^ flip) < (b ^ flip);
    endfunction

    function void append_key(int side, key_t key);
      if (fill[side] >= SET_DEPTH) begin
        load_flags[FLAG_OVERFLOW] = 1'b1;
      end else if (fill[side] > 0 && !key_below(key_store[side][fill[side]-1], key)) begin
        load_flags[FLAG_DISORDER] = 1'b1;
      end else begin
        key_store[side][fill[side]] = key;
        fill[side]++;
      end
    endfunction

    function void push_key(key_t key);
      out_item_t beat;
      beat.out_key = key;
      beat.has_key = 1'b1;
      beat.last    = 1'b0;
      beat.status  = load_flags;
      merged_beats.push_back(beat);
    endfunction

    // two-pointer walk; tails kept only where the operation wants them
    function void merge_sets();
      int i;
      int j;
      int base;
      bit keep_left;
      bit keep_right;
      bit keep_common;
      out_item_t beat;
      base        = merged_beats.size();
      keep_left   = (set_op != SET_INTER);
      keep_right  = (set_op == SET_OR) || (set_op == SET_XOR);
      keep_common = (set_op == SET_OR) || (set_op == SET_INTER);
      i = 0;
      j = 0;
      while (i < fill[LEFT_SIDE] && j < fill[RIGHT_SIDE]) begin
        if (key_below(key_store[LEFT_SIDE][i], key_store[RIGHT_SIDE][j])) begin
          if (keep_left) push_key(key_store[LEFT_SIDE][i]);
          i++;
        end else if (key_below(key_store[RIGHT_SIDE][j], key_store[LEFT_SIDE][i])) begin
          if (keep_right) push_key(key_store[RIGHT_SIDE][j]);
          j++;
        end else begin
          if (keep_common) push_key(key_store[LEFT_SIDE][i]);
          i++;
          j++;
        end
      end
      while (i < fill[LEFT_SIDE]) begin
        if (keep_left) push_key(key_store[LEFT_SIDE][i]);
        i++;
      end
      while (j < fill[RIGHT_SIDE]) begin
        if (keep_right) push_key(key_store[RIGHT_SIDE][j]);
        j++;
      end
      if (merged_beats.size() == base) begin
        beat        = '0;
        beat.last   = 1'b1;
        beat.status = load_flags;
        merged_beats.push_back(beat);
      end else begin
        merged_beats[merged_beats.size()-1].last = 1'b1;
      end
      fill[LEFT_SIDE]  = 0;
      fill[RIGHT_SIDE] = 0;
      load_flags       = '0;
    endfunction

    function void note_input(in_item_t beat);
      case (beat.operation)
        OP_LOAD_LEFT:  append_key(LEFT_SIDE, beat.key);
        OP_LOAD_RIGHT: append_key(RIGHT_SIDE, beat.key);
        OP_RUN:        merge_sets();
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (merged_beats.size() == 0) begin
        report($sformatf("result beat with nothing pending: key %h", got.out_key));
        return;
      end
      want = merged_beats.pop_front();
      if (got.out_key !== want.out_key)
        report($sformatf("out_key %h, predicted %h", got.out_key, want.out_key));
      if (got.has_key !== want.has_key)
        report($sformatf("has_key %b, predicted %b", got.has_key, want.has_key));
      if (got.last !== want.last)
        report($sformatf("last %b, predicted %b", got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("status %b, predicted %b", got.status, want.status));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic       cfg_idx;
  logic [1:0] cfg_wdata;

  merge_checker chk;
  int           gap_pct;   // chance in a hundred of idling before a beat

  sorted_set_merge_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Results cannot be held off: every strobed cycle is a beat, taken at
  // the edge that ends it. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_valid) chk.check_result(out_item);
  end

  // Present one beat, maybe after a random idle gap, and hold it until an
  // edge sees start high with busy low. Returns at that edge, so the next
  // call assigns start only once in the same time step.
  task automatic send_beat(logic [1:0] op, key_t key);
    in_item_t beat;
    beat.operation = op;
    beat.key       = key;
    if ($urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    chk.note_input(beat);
  endtask

  // Stop sending until every predicted beat is back and loads have settled.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (chk.merged_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle. The trailing edge keeps back-to-back writes
  // from driving cfg_we twice in one time step.
  task automatic write_register(logic idx, logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.set_register(idx, value);
    @(posedge clk);
  endtask

  initial begin
    int         gap_by_phase[4];
    int         counted;
    int         kind;
    int         pool_size;
    int         pick_side;
    bit         big_first;
    logic [1:0] op;
    key_t       flip;
    key_t       key;
    bit [31:0]  pool[$];

    chk       = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = 1'b0;
    cfg_wdata = '0;
    gap_pct   = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, registers at reset: union, unsigned ----

    // nothing loaded: a single beat with has_key low
    send_beat(OP_RUN, $urandom);
    // extreme keys, a repeated key (dropped, out of order), an ignored code
    send_beat(OP_LOAD_LEFT, 32'h0000_0000);
    send_beat(OP_LOAD_LEFT, 32'hFFFF_FFFF);
    send_beat(OP_LOAD_LEFT, 32'hFFFF_FFFF);
    send_beat(OP_LOAD_RIGHT, 32'h0000_0000);
    send_beat(OP_LOAD_RIGHT, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_RIGHT, 32'h8000_0000);
    send_beat(OP_IGNORED, 32'h5A5A_A5A5);
    send_beat(OP_RUN, 32'hFFFF_FFFF);

    // intersection: the left-only key dropped, the common key kept
    wait_idle();
    write_register(CFG_SET_OP, SET_INTER);
    send_beat(OP_LOAD_LEFT, 32'd5);
    send_beat(OP_LOAD_LEFT, 32'd9);
    send_beat(OP_LOAD_RIGHT, 32'd9);
    send_beat(OP_RUN, 32'd0);

    // difference: the common key goes, the left one stays
    wait_idle();
    write_register(CFG_SET_OP, SET_DIFF);
    send_beat(OP_LOAD_LEFT, 32'd1);
    send_beat(OP_LOAD_LEFT, 32'd2);
    send_beat(OP_LOAD_RIGHT, 32'd2);
    send_beat(OP_RUN, 32'd0);

    // symmetric difference of equal sets: empty result
    wait_idle();
    write_register(CFG_SET_OP, SET_XOR);
    send_beat(OP_LOAD_LEFT, 32'd3);
    send_beat(OP_LOAD_RIGHT, 32'd3);
    send_beat(OP_RUN, 32'd0);

    // signed union across the sign boundary
    wait_idle();
    write_register(CFG_SET_OP, SET_OR);
    write_register(CFG_SIGNED, 2'd1);
    send_beat(OP_LOAD_LEFT, 32'hFFFF_FFFF);
    send_beat(OP_LOAD_LEFT, 32'h0000_0001);
    send_beat(OP_LOAD_RIGHT, 32'h8000_0000);
    send_beat(OP_RUN, 32'd0);

    // loaded in signed order, then run unsigned on the stored order
    wait_idle();
    send_beat(OP_LOAD_LEFT, 32'hFFFF_FFFB);
    send_beat(OP_LOAD_LEFT, 32'h0000_0003);
    wait_idle();
    write_register(CFG_SIGNED, 2'd0);
    send_beat(OP_RUN, 32'd0);

    // ---- random part ----
    // Idle phases by progress: none, sender gaps, none, sender gaps again.
    gap_by_phase = '{0, 55, 0, 38};
    counted   = 0;
    big_first = 1'b1;
    while (counted < RANDOM_BEATS) begin
      gap_pct = gap_by_phase[counted * 4 / RANDOM_BEATS];

      // retune between runs; the pause also drains everything in flight
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_register(CFG_SET_OP, 2'($urandom_range(0, 3)));
        write_register(CFG_SIGNED, 2'($urandom_range(0, 3)));
      end

      kind = $urandom_range(0, 99);
      if (kind < 15 && !big_first) begin
        // noise: any code, any key, no closing run
        repeat ($urandom_range(1, 6)) begin
          op = 2'($urandom_range(0, 3));
          send_beat(op, $urandom);
          if (op != OP_IGNORED) counted++;
        end
      end else begin
        // well-formed sets drawn from one sorted pool so the sides overlap;
        // large pools can overflow the stores
        pool_size = (big_first || kind >= 92) ? $urandom_range(28, 70)
                                              : $urandom_range(0, 10);
        flip = chk.signed_keys ? 32'h8000_0000 : 32'h0;
        pool.delete();
        repeat (pool_size) begin
          case ($urandom_range(0, 3))
            0:       key = $urandom_range(0, 40);
            1:       key = 32'h7FFF_FFE0 + $urandom_range(0, 64);
            default: key = $urandom;
          endcase
          pool.push_back(key ^ flip);
        end
        pool.sort();
        for (int k = 0; k < pool.size(); k++) begin
          if (k > 0 && pool[k] == pool[k-1]) continue;
          key = pool[k] ^ flip;
          // 0 left only, 1 right only, 2 both sides
          pick_side = $urandom_range(0, 2);
          if (pick_side != 1) begin
            send_beat(OP_LOAD_LEFT, key);
            counted++;
          end
          if (pick_side != 0) begin
            send_beat(OP_LOAD_RIGHT, key);
            counted++;
          end
          // now and then break the order with a repeat
          if ($urandom_range(0, 49) == 0) begin
            send_beat(pick_side == 1 ? OP_LOAD_RIGHT : OP_LOAD_LEFT, key);
            counted++;
          end
        end
        send_beat(OP_RUN, $urandom);
        counted++;
        big_first = 1'b0;
      end
    end

    // drain and let the engine settle
    wait_idle();
    if (chk.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3ms;
    $display("run timed out waiting on the merge engine");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
